### src/variable_length_record_ring_queue_top_macros.svh
// Assertion macros for the record ring queue.
// Used by the back-end module; needs i_clk and i_rst_n in scope.
`ifndef VARIABLE_LENGTH_RECORD_RING_QUEUE_TOP_MACROS_SVH
`define VARIABLE_LENGTH_RECORD_RING_QUEUE_TOP_MACROS_SVH

// Invariant checked every clock outside reset.
`define VLRQ_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Implication checked every clock outside reset.
`define VLRQ_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### src/vlrq_pkg.sv
// Shared types and codes for the record ring queue.
// No dependencies.
package vlrq_pkg;
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int CW = 18;

    localparam logic [2:0] OP_HDR   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_OPEN  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_BAD   = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_SEQ     = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] identifier;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [15:0] reader_capacity;
    } t_item;
endpackage

### src/variable_length_record_ring_queue_top.sv
// Record ring queue, top level: a byte ring holding whole variable-length records.
// Depends on vlrq_pkg, vlrq_front and vlrq_back.
//
// Usage: drive the item fields with start high; the item is taken on a clock
// edge where start is high and busy is low. Kinds: insert header, payload
// byte, open next record, read byte, clear. Every item gives exactly one
// result, shown for one cycle with o_strobe high; the receiver cannot stall.
// Accepted headers write four header bytes through the single store port,
// and open reads the four header bytes back before it answers. Items run one
// at a time in the back end; a two-entry queue in front takes new items while
// one is at work, and busy rises when that queue is full and while reset is
// held. The back end takes no new item until the last one has given its
// result, so the throughput is set by the single-port byte store.
// Reset (i_rst_n low at a clock edge) empties the queue and clears all
// positions and counts; store contents stay undefined until written and no
// clearing pass is run.
module variable_length_record_ring_queue_top #(
    parameter int BUFFER_BYTES = vlrq_pkg::BUFFER_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [2:0]   i_kind,
    input  logic [15:0]  i_identifier,
    input  logic [15:0]  i_payload_length,
    input  logic [7:0]   i_data_byte,
    input  logic [15:0]  i_reader_capacity,
    output logic         o_strobe,
    output logic [2:0]   o_status,
    output logic [15:0]  o_record_identifier,
    output logic [15:0]  o_record_length,
    output logic [7:0]   o_read_byte,
    output logic         o_last,
    output logic [10:0]  o_records_held,
    output logic [12:0]  o_bytes_held
);
    import vlrq_pkg::*;

    t_item item;
    logic  item_valid;
    logic  item_pop;

    vlrq_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_identifier      (i_identifier),
        .i_payload_length  (i_payload_length),
        .i_data_byte       (i_data_byte),
        .i_reader_capacity (i_reader_capacity),
        .o_valid           (item_valid),
        .o_item            (item),
        .i_pop             (item_pop)
    );

    vlrq_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (item_valid),
        .i_item              (item),
        .o_pop               (item_pop),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_record_identifier (o_record_identifier),
        .o_record_length     (o_record_length),
        .o_read_byte         (o_read_byte),
        .o_last              (o_last),
        .o_records_held      (o_records_held),
        .o_bytes_held        (o_bytes_held)
    );
endmodule

### src/vlrq_front.sv
// Front end: accepts items, classifies the kind, queues them two deep.
// Depends on vlrq_pkg.
module vlrq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_kind,
    input  logic [15:0]         i_identifier,
    input  logic [15:0]         i_payload_length,
    input  logic [7:0]          i_data_byte,
    input  logic [15:0]         i_reader_capacity,
    output logic                o_valid,
    output vlrq_pkg::t_item     o_item,
    input  logic                i_pop
);
    import vlrq_pkg::*;

    t_item       r_slot [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;
    t_item       item;

    assign busy    = (r_cnt == 2'd2) || !i_rst_n;
    assign push    = start && !busy;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = i_pop && o_valid;
    assign o_item  = r_slot[r_rp];

    always_comb begin
        item.op              = (i_kind > OP_CLEAR) ? OP_BAD : i_kind;
        item.identifier      = i_identifier;
        item.payload_length  = i_payload_length;
        item.data_byte       = i_data_byte;
        item.reader_capacity = i_reader_capacity;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

### src/vlrq_back.sv
// Back end: ring store, positions and counts; executes one item at a time.
// Depends on vlrq_pkg and the assertion macro header.
`include "variable_length_record_ring_queue_top_macros.svh"
module vlrq_back #(
    parameter int BUFFER_BYTES = vlrq_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  vlrq_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [2:0]          o_status,
    output logic [15:0]         o_record_identifier,
    output logic [15:0]         o_record_length,
    output logic [7:0]          o_read_byte,
    output logic                o_last,
    output logic [10:0]         o_records_held,
    output logic [12:0]         o_bytes_held
);
    import vlrq_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int PW = AW + 1;
    localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);
    localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HW   = 2'd1;
    localparam logic [1:0] S_OPEN = 2'd2;
    localparam logic [1:0] S_RB   = 2'd3;

    typedef struct packed {
        logic [PW-1:0] occ;
        logic [PW-1:0] cnt;
    } t_rel;

    function automatic t_rel f_release(input logic [PW-1:0] cur, input logic [PW-1:0] rd,
                                       input logic [PW-1:0] occ, input logic [PW-1:0] cnt);
        t_rel          r;
        logic [PW-1:0] size;
        size  = (cur >= rd) ? cur - rd : '0;
        r.occ = (occ >= size) ? occ - size : '0;
        r.cnt = (cnt != '0) ? cnt - 1'b1 : cnt;
        return r;
    endfunction

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_q;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wd;

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_k, n_k;
    logic [31:0]   r_hdr, n_hdr;
    logic [PW-1:0] r_base, n_base;
    logic [15:0]   r_cap, n_cap;
    logic [PW-1:0] r_ins, n_ins, r_term, n_term, r_rd, n_rd, r_occ, n_occ, r_cnt, n_cnt;
    logic [PW-1:0] r_wcur, n_wcur, r_rcur, n_rcur;
    logic [15:0]   r_wrem, n_wrem, r_rrem, n_rrem;
    logic          r_rej, n_rej;
    logic          r_stb, n_stb, r_last, n_last;
    logic [2:0]    r_st, n_st;
    logic [15:0]   r_id, n_id, r_len, n_len;
    logic [7:0]    r_byte, n_byte;

    logic          pop;
    logic [CW-1:0] need, p;
    logic          full;
    logic [31:0]   hdr_all;
    logic [PW-1:0] cur;
    logic [PW-1:0] seq_pos;
    t_rel          rel;

    assign pop      = (r_state == S_IDLE) && i_valid;
    assign o_pop    = pop;
    assign hdr_all  = {r_q, r_hdr[31:8]};
    assign seq_pos  = r_base + PW'(r_k);

    always_comb begin
        n_state = r_state; n_k = r_k; n_hdr = r_hdr; n_base = r_base; n_cap = r_cap;
        n_ins = r_ins; n_term = r_term; n_rd = r_rd; n_occ = r_occ; n_cnt = r_cnt;
        n_wcur = r_wcur; n_rcur = r_rcur; n_wrem = r_wrem; n_rrem = r_rrem; n_rej = r_rej;
        n_stb = 1'b0; n_st = ST_OK; n_id = '0; n_len = '0; n_byte = '0; n_last = 1'b0;
        mem_we = 1'b0; mem_addr = r_rcur[AW-1:0]; mem_wd = '0;
        need = HDR_C + CW'(i_item.payload_length);
        p = CW'(r_ins); full = 1'b0; cur = '0; rel = '0;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_item.op)
                        OP_HDR: begin
                            if (r_wrem != '0) begin
                                n_stb = 1'b1; n_st = ST_SEQ;
                            end else begin
                                if (CW'(r_occ) + need > BUF_C) full = 1'b1;
                                if (!full && r_ins == r_term && p + need > BUF_C) begin
                                    if (CW'(r_rd) >= need) p = '0;
                                    else full = 1'b1;
                                end
                                if (!full && p < CW'(r_term) && p + need > CW'(r_rd))
                                    full = 1'b1;
                                if (!full && p + need > CW'(r_rd) && CW'(r_rd) >= p
                                    && r_occ != '0)
                                    full = 1'b1;
                                n_wrem = i_item.payload_length;
                                if (full) begin
                                    n_rej = (i_item.payload_length != '0);
                                    n_stb = 1'b1; n_st = ST_FULL;
                                end else begin
                                    n_rej  = 1'b0;
                                    n_base = PW'(p);
                                    n_wcur = PW'(p + HDR_C);
                                    n_ins  = PW'(p + need);
                                    if (PW'(p + need) > r_term) n_term = PW'(p + need);
                                    n_occ  = PW'(CW'(r_occ) + need);
                                    if (i_item.payload_length == '0) n_cnt = r_cnt + 1'b1;
                                    n_hdr  = {i_item.payload_length, i_item.identifier};
                                    n_k    = '0;
                                    n_state = S_HW;
                                end
                            end
                        end
                        OP_DATA: begin
                            n_stb = 1'b1;
                            if (r_wrem == '0) begin
                                n_st = ST_SEQ;
                            end else begin
                                n_wrem = r_wrem - 1'b1;
                                if (r_rej) begin
                                    n_st = ST_FULL;
                                    if (r_wrem == 16'd1) n_rej = 1'b0;
                                end else begin
                                    mem_we   = 1'b1;
                                    mem_addr = r_wcur[AW-1:0];
                                    mem_wd   = i_item.data_byte;
                                    n_wcur   = r_wcur + 1'b1;
                                    if (r_wrem == 16'd1) n_cnt = r_cnt + 1'b1;
                                end
                            end
                        end
                        OP_OPEN: begin
                            if (r_rrem != '0) begin
                                n_stb = 1'b1; n_st = ST_SEQ;
                            end else if (r_cnt == '0 || r_occ == '0) begin
                                n_stb = 1'b1; n_st = ST_EMPTY;
                            end else begin
                                if (r_rd == r_term) begin
                                    n_rd = '0; n_term = r_ins; n_base = '0;
                                end else begin
                                    n_base = r_rd;
                                end
                                n_cap = i_item.reader_capacity;
                                n_k = '0;
                                n_state = S_OPEN;
                            end
                        end
                        OP_READ: begin
                            if (r_rrem == '0) begin
                                n_stb = 1'b1; n_st = ST_SEQ;
                            end else begin
                                mem_addr = r_rcur[AW-1:0];
                                n_state = S_RB;
                            end
                        end
                        OP_CLEAR: begin
                            n_ins = '0; n_term = '0; n_rd = '0; n_occ = '0; n_cnt = '0;
                            n_wrem = '0; n_wcur = '0; n_rrem = '0; n_rcur = '0; n_rej = 1'b0;
                            n_stb = 1'b1;
                        end
                        default: begin
                            n_stb = 1'b1; n_st = ST_SEQ;
                        end
                    endcase
                end
            end
            S_HW: begin
                mem_we   = 1'b1;
                mem_addr = seq_pos[AW-1:0];
                mem_wd   = r_hdr[7:0];
                n_hdr    = {8'd0, r_hdr[31:8]};
                n_k      = r_k + 1'b1;
                if (r_k == 3'd3) begin
                    n_stb = 1'b1; n_state = S_IDLE;
                end
            end
            S_OPEN: begin
                mem_addr = seq_pos[AW-1:0];
                if (r_k != '0) n_hdr = hdr_all;
                n_k = r_k + 1'b1;
                if (r_k == 3'd4) begin
                    n_stb   = 1'b1;
                    n_state = S_IDLE;
                    n_id    = hdr_all[15:0];
                    cur     = r_base + PW'(HEADER_BYTES);
                    if (r_cap >= hdr_all[31:16]) begin
                        n_len  = hdr_all[31:16];
                        n_rrem = hdr_all[31:16];
                    end else begin
                        n_st = ST_DROPPED;
                        cur  = PW'(CW'(r_base) + HDR_C + CW'(hdr_all[31:16]));
                    end
                    n_rcur = cur;
                    if (r_cap < hdr_all[31:16] || hdr_all[31:16] == '0) begin
                        rel   = f_release(cur, r_rd, r_occ, r_cnt);
                        n_occ = rel.occ; n_cnt = rel.cnt; n_rd = cur;
                    end
                end
            end
            S_RB: begin
                n_stb   = 1'b1;
                n_state = S_IDLE;
                n_byte  = r_q;
                cur     = r_rcur + 1'b1;
                n_rcur  = cur;
                n_rrem  = r_rrem - 1'b1;
                if (r_rrem == 16'd1) begin
                    n_last = 1'b1;
                    rel    = f_release(cur, r_rd, r_occ, r_cnt);
                    n_occ  = rel.occ; n_cnt = rel.cnt; n_rd = cur;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_q <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_hdr <= n_hdr; r_base <= n_base; r_cap <= n_cap;
        r_st <= n_st; r_id <= n_id; r_len <= n_len; r_byte <= n_byte; r_last <= n_last;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ins <= '0; r_term <= '0; r_rd <= '0; r_occ <= '0; r_cnt <= '0;
            r_wcur <= '0; r_rcur <= '0; r_wrem <= '0; r_rrem <= '0; r_rej <= 1'b0;
            r_stb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ins <= n_ins; r_term <= n_term; r_rd <= n_rd; r_occ <= n_occ; r_cnt <= n_cnt;
            r_wcur <= n_wcur; r_rcur <= n_rcur; r_wrem <= n_wrem; r_rrem <= n_rrem;
            r_rej <= n_rej;
            r_stb <= n_stb;
        end
    end

    assign o_strobe            = r_stb;
    assign o_status            = r_st;
    assign o_record_identifier = r_id;
    assign o_record_length     = r_len;
    assign o_read_byte         = r_byte;
    assign o_last              = r_last;
    assign o_records_held      = 11'(r_cnt);
    assign o_bytes_held        = 13'(r_occ);

    `VLRQ_HOLDS(a_occ_bound, r_occ <= PW'(BUFFER_BYTES), "occupied bytes exceed buffer")
    `VLRQ_IMPLIES(a_rej_open, r_rej, r_wrem != '0, "refused insert with no bytes pending")
    `VLRQ_IMPLIES(a_read_has_rec, r_rrem != '0, r_cnt != '0, "open read with no record held")
    `VLRQ_IMPLIES(a_no_pop_busy, r_state != S_IDLE, !o_pop, "item taken while working")
endmodule
